// ===== src/assert_macros.svh =====
// Assertion macros used by the rss_checker module.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rss_pkg.sv =====
// Shared types and constants for the running sample statistics block.
// No dependencies.
package rss_pkg;

    // Largest set; the sample that fills it closes the set
    localparam int MAX_ITEMS = 8192;

    localparam int SMP_W  = 32;
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int IDX_W  = $clog2(MAX_ITEMS);
    localparam int SUM_W  = SMP_W + IDX_W + 1;
    localparam int FRAC_W = 8;
    localparam int AVG_W  = 40;
    localparam int DEV_W  = 32;
    localparam int DIVD_W = SUM_W + FRAC_W;
    localparam int ITER_W = $clog2(DIVD_W + 1);

    typedef logic signed [SMP_W-1:0]  sample_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic [DIVD_W-1:0]        divd_t;
    typedef logic [ITER_W-1:0]        iter_t;
    typedef logic signed [AVG_W-1:0]  avg_t;
    typedef logic [DEV_W-1:0]         dev_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;     // take the input word into the statistics
        logic div_start;  // launch the division of the sum by the count
        logic deliver;    // load the result register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic div_busy;
    } status_t;

    // One result word
    typedef struct packed {
        cnt_t    count;
        sample_t max_value;
        idx_t    max_index;
        sample_t min_value;
        idx_t    min_index;
        sample_t mode_value;
        avg_t    average_q8;
        dev_t    max_deviation;
        logic    set_done;
    } result_t;

endpackage

// ===== src/rss_in_if.sv =====
// Input channel: one sample word per handshake.
// Depends on rss_pkg.
interface rss_in_if;
    logic             valid;
    logic             ready;
    rss_pkg::sample_t sample;
    logic             last;

    modport source (output valid, sample, last, input ready);
    modport sink (input valid, sample, last, output ready);
    modport monitor (input valid, ready, sample, last);
endinterface

// ===== src/rss_out_if.sv =====
// Output channel: one statistics word per handshake.
// Depends on rss_pkg.
interface rss_out_if;
    logic             valid;
    logic             ready;
    rss_pkg::cnt_t    count;
    rss_pkg::sample_t max_value;
    rss_pkg::idx_t    max_index;
    rss_pkg::sample_t min_value;
    rss_pkg::idx_t    min_index;
    rss_pkg::sample_t mode_value;
    rss_pkg::avg_t    average_q8;
    rss_pkg::dev_t    max_deviation;
    logic             set_done;

    modport source (output valid, count, max_value, max_index, min_value, min_index,
                    mode_value, average_q8, max_deviation, set_done, input ready);
    modport sink (input valid, count, max_value, max_index, min_value, min_index,
                  mode_value, average_q8, max_deviation, set_done, output ready);
    modport monitor (input valid, ready, count, max_value, max_index, min_value,
                     min_index, mode_value, average_q8, max_deviation, set_done);
endinterface

// ===== src/rss_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
// Unsigned dividend of DIVD_W bits by a non-zero count. Depends on rss_pkg.
module rss_div (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  rss_pkg::divd_t dividend,
    input  rss_pkg::cnt_t  divisor,
    output logic          busy,
    output rss_pkg::divd_t quotient
);

    rss_pkg::divd_t quo_reg, quo_next;
    rss_pkg::cnt_t  rem_reg, rem_next;
    rss_pkg::cnt_t  dsr_reg, dsr_next;
    rss_pkg::iter_t iter_reg, iter_next;
    logic           busy_reg, busy_next;

    logic [rss_pkg::CNT_W:0] trial;
    logic [rss_pkg::CNT_W:0] diff;
    logic                    ge;

    // One shift-subtract step
    always_comb
    begin
        trial = {rem_reg, quo_reg[rss_pkg::DIVD_W-1]};
        ge    = (trial >= {1'b0, dsr_reg});
        diff  = trial - {1'b0, dsr_reg};
    end

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        iter_next = iter_reg;
        busy_next = busy_reg;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            iter_next = rss_pkg::iter_t'(rss_pkg::DIVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so the top bit drops
            rem_next  = ge ? diff[rss_pkg::CNT_W-1:0] : trial[rss_pkg::CNT_W-1:0];
            quo_next  = {quo_reg[rss_pkg::DIVD_W-2:0], ge};
            iter_next = iter_reg - rss_pkg::iter_t'(1);
            busy_next = (iter_reg != rss_pkg::iter_t'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            iter_reg <= iter_next;
        end
    end

    // Operand registers need no reset
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ===== src/rss_datapath.sv =====
// Statistics registers, result register and the shared divider.
// Depends on rss_pkg and rss_div.
module rss_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  rss_pkg::cmd_t     cmd,
    output rss_pkg::status_t  status,
    input  rss_pkg::sample_t  in_sample,
    input  logic              in_last,
    output rss_pkg::result_t  result
);

    // Statistics state
    rss_pkg::cnt_t    cnt_reg, cnt_next;
    rss_pkg::sum_t    sum_reg, sum_next;
    rss_pkg::sample_t max_reg, max_next;
    rss_pkg::idx_t    max_pos_reg, max_pos_next;
    rss_pkg::sample_t min_reg, min_next;
    rss_pkg::idx_t    min_pos_reg, min_pos_next;
    rss_pkg::sample_t prev_reg, prev_next;
    rss_pkg::cnt_t    run_reg, run_next;
    rss_pkg::cnt_t    longest_reg, longest_next;
    rss_pkg::sample_t mode_reg, mode_next;
    rss_pkg::dev_t    worst_reg, worst_next;

    // Per-word working registers
    rss_pkg::sample_t smp_reg, smp_next;
    logic             first_reg, first_next;
    logic             done_reg, done_next;
    logic             neg_reg, neg_next;
    rss_pkg::result_t res_reg, res_next;

    // Divider hookup
    rss_pkg::sum_t  abs_sum;
    rss_pkg::divd_t dividend;
    rss_pkg::divd_t quotient;
    logic           div_busy;

    // Result arithmetic
    rss_pkg::cnt_t                    cnt_inc;
    rss_pkg::cnt_t                    run_calc;
    logic [rss_pkg::AVG_W-1:0]        avg_mag;
    logic signed [rss_pkg::SMP_W:0]   mean_mag;
    logic signed [rss_pkg::SMP_W:0]   mean;
    logic signed [rss_pkg::SMP_W+1:0] dev_diff;
    logic [rss_pkg::SMP_W+1:0]        dev_abs;
    rss_pkg::dev_t                    dev;
    rss_pkg::dev_t                    worst_upd;

    // Dividend is |sum| scaled by 2^8; its quotient gives both average and mean
    assign abs_sum  = sum_reg[rss_pkg::SUM_W-1] ? -sum_reg : sum_reg;
    assign dividend = {abs_sum, {rss_pkg::FRAC_W{1'b0}}};

    rss_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (cnt_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign status.div_busy = div_busy;

    // Increment helpers
    assign cnt_inc  = cnt_reg + rss_pkg::cnt_t'(1);
    assign run_calc = (in_sample == prev_reg) ? run_reg + rss_pkg::cnt_t'(1)
                                              : rss_pkg::cnt_t'(1);

    // Average and mean from the quotient, truncated toward zero
    always_comb
    begin
        avg_mag  = quotient[rss_pkg::AVG_W-1:0];
        mean_mag = {1'b0, quotient[rss_pkg::FRAC_W +: rss_pkg::SMP_W]};
        mean     = neg_reg ? -mean_mag : mean_mag;
        dev_diff = {{2{smp_reg[rss_pkg::SMP_W-1]}}, smp_reg}
                 - {mean[rss_pkg::SMP_W], mean};
        dev_abs  = dev_diff[rss_pkg::SMP_W+1] ? -dev_diff : dev_diff;
        dev      = dev_abs[rss_pkg::DEV_W-1:0];
        if (first_reg)
            worst_upd = '0;
        else if (dev > worst_reg)
            worst_upd = dev;
        else
            worst_upd = worst_reg;
    end

    // Next-state logic
    always_comb
    begin
        cnt_next     = cnt_reg;
        sum_next     = sum_reg;
        max_next     = max_reg;
        max_pos_next = max_pos_reg;
        min_next     = min_reg;
        min_pos_next = min_pos_reg;
        prev_next    = prev_reg;
        run_next     = run_reg;
        longest_next = longest_reg;
        mode_next    = mode_reg;
        worst_next   = worst_reg;
        smp_next     = smp_reg;
        first_next   = first_reg;
        done_next    = done_reg;
        neg_next     = neg_reg;
        res_next     = res_reg;

        // Fold the accepted sample into the statistics
        if (cmd.accept)
        begin
            smp_next   = in_sample;
            prev_next  = in_sample;
            cnt_next   = cnt_inc;
            first_next = (cnt_reg == '0);
            done_next  = in_last || (cnt_inc == rss_pkg::cnt_t'(rss_pkg::MAX_ITEMS));
            if (cnt_reg == '0)
            begin
                sum_next     = rss_pkg::sum_t'(in_sample);
                max_next     = in_sample;
                max_pos_next = '0;
                min_next     = in_sample;
                min_pos_next = '0;
                run_next     = rss_pkg::cnt_t'(1);
                longest_next = rss_pkg::cnt_t'(1);
                mode_next    = in_sample;
            end
            else
            begin
                // minimum tested only when the sample is not a new maximum
                if (in_sample > max_reg)
                begin
                    max_next     = in_sample;
                    max_pos_next = cnt_reg[rss_pkg::IDX_W-1:0];
                end
                else if (in_sample < min_reg)
                begin
                    min_next     = in_sample;
                    min_pos_next = cnt_reg[rss_pkg::IDX_W-1:0];
                end
                sum_next = sum_reg + rss_pkg::sum_t'(in_sample);
                run_next = run_calc;
                if (run_calc > longest_reg ||
                    (run_calc == longest_reg && in_sample > mode_reg))
                begin
                    longest_next = run_calc;
                    mode_next    = in_sample;
                end
            end
        end

        // Sign of the sum for the divider result
        if (cmd.div_start)
            neg_next = sum_reg[rss_pkg::SUM_W-1];

        // Capture the result word, then clear the set if it is closed
        if (cmd.deliver)
        begin
            res_next.count         = cnt_reg;
            res_next.max_value     = max_reg;
            res_next.max_index     = max_pos_reg;
            res_next.min_value     = min_reg;
            res_next.min_index     = min_pos_reg;
            res_next.mode_value    = mode_reg;
            res_next.average_q8    = neg_reg ? rss_pkg::avg_t'(-avg_mag)
                                             : rss_pkg::avg_t'(avg_mag);
            res_next.max_deviation = worst_upd;
            res_next.set_done      = done_reg;
            if (done_reg)
            begin
                cnt_next     = '0;
                sum_next     = '0;
                max_next     = '0;
                max_pos_next = '0;
                min_next     = '0;
                min_pos_next = '0;
                prev_next    = '0;
                run_next     = '0;
                longest_next = '0;
                mode_next    = '0;
                worst_next   = '0;
            end
            else
            begin
                worst_next = worst_upd;
            end
        end
    end

    // Statistics state, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            sum_reg     <= '0;
            max_reg     <= '0;
            max_pos_reg <= '0;
            min_reg     <= '0;
            min_pos_reg <= '0;
            prev_reg    <= '0;
            run_reg     <= '0;
            longest_reg <= '0;
            mode_reg    <= '0;
            worst_reg   <= '0;
        end
        else
        begin
            cnt_reg     <= cnt_next;
            sum_reg     <= sum_next;
            max_reg     <= max_next;
            max_pos_reg <= max_pos_next;
            min_reg     <= min_next;
            min_pos_reg <= min_pos_next;
            prev_reg    <= prev_next;
            run_reg     <= run_next;
            longest_reg <= longest_next;
            mode_reg    <= mode_next;
            worst_reg   <= worst_next;
        end
    end

    // Working and result registers
    always_ff @(posedge clk)
    begin
        smp_reg   <= smp_next;
        first_reg <= first_next;
        done_reg  <= done_next;
        neg_reg   <= neg_next;
        res_reg   <= res_next;
    end

    assign result = res_reg;

endmodule

// ===== src/rss_ctrl.sv =====
// Sequencer: accept a word, run the divider, load the result register.
// Depends on rss_pkg.
module rss_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  rss_pkg::status_t status,
    output rss_pkg::cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    // Result register may be loaded when empty or being drained
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (!status.div_busy)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.deliver    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== src/running_sample_statistics.sv =====
// Running sample statistics: for every signed 32-bit sample word of a set, one result
// word gives count, max and min with their first positions, the mode of the longest
// equal run, the average in Q.8 and the largest deviation from the truncated mean. A
// word with last set, or the word that fills a set of MAX_ITEMS, closes the set and
// clears the statistics after its result. One word is in flight at a time: a sample
// passes through divider load, 54 steps of the radix-2 divider over |sum| * 256, a
// state to see the divider finish and the result load, and the next sample is taken
// only after that load, which waits while an earlier result word is still unread.
// The output register lets a new sample enter while a result waits.
module running_sample_statistics (
    input  logic      clk,
    input  logic      rst_n,
    rss_in_if.sink    samples,
    rss_out_if.source results
);

    rss_pkg::cmd_t    cmd;
    rss_pkg::status_t status;
    rss_pkg::result_t result;

    rss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .status    (status),
        .cmd       (cmd)
    );

    rss_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_sample (samples.sample),
        .in_last   (samples.last),
        .result    (result)
    );

    // Result word onto the output channel
    assign results.count         = result.count;
    assign results.max_value     = result.max_value;
    assign results.max_index     = result.max_index;
    assign results.min_value     = result.min_value;
    assign results.min_index     = result.min_index;
    assign results.mode_value    = result.mode_value;
    assign results.average_q8    = result.average_q8;
    assign results.max_deviation = result.max_deviation;
    assign results.set_done      = result.set_done;

endmodule

// ===== src/rss_checker.sv =====
// Port-level checks for running_sample_statistics, attached by bind.
// Depends on rss_pkg, the channel interfaces and assert_macros.svh.
`include "assert_macros.svh"

module rss_checker (
    input logic        clk,
    input logic        rst_n,
    rss_in_if.sink     samples,
    rss_out_if.source  results
);

    // A stalled result word stays offered
    `ASSERT_NEXT(a_out_hold, results.valid && !results.ready, results.valid, "result word dropped while stalled")

    // Only one sample in flight: no back-to-back acceptance
    `ASSERT_NEXT(a_one_in_flight, samples.valid && samples.ready, !samples.ready, "sample accepted while another is in flight")

    // Count stays within the set size
    `ASSERT_IMPL(a_count_range, results.valid, results.count != '0 && results.count <= rss_pkg::cnt_t'(rss_pkg::MAX_ITEMS), "count out of range")

    // A full set is always closed
    `ASSERT_IMPL(a_full_closes, results.valid && results.count == rss_pkg::cnt_t'(rss_pkg::MAX_ITEMS), results.set_done, "full set not closed")

    // Recorded positions lie within the samples seen
    `ASSERT_IMPL(a_index_range, results.valid, {1'b0, results.max_index} < results.count && {1'b0, results.min_index} < results.count, "extreme index beyond count")

endmodule

bind running_sample_statistics rss_checker u_rss_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .samples (samples),
    .results (results)
);

// ===== tb/sv/rss_stats_checker.sv =====
// Checker for running_sample_statistics: watches both channels, predicts each result word
// and compares it field by field. Depends on rss_pkg, rss_in_if and rss_out_if.
module rss_stats_checker (
    input  logic       clk,
    input  logic       rst_n,
    rss_in_if.monitor  samples,
    rss_out_if.monitor results,
    output int         errors,
    output int         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Predicted statistics of the set in progress
    int               n_seen;
    longint           sum_acc;
    rss_pkg::sample_t hi_val;
    rss_pkg::idx_t    hi_pos;
    rss_pkg::sample_t lo_val;
    rss_pkg::idx_t    lo_pos;
    rss_pkg::sample_t prev_smp;
    int               run_len;
    int               best_run;
    rss_pkg::sample_t mode_val;
    longint           dev_peak;

    rss_pkg::result_t stats_due[$];
    int               words_checked;

    initial
    begin
        errors        = 0;
        pending       = 0;
        words_checked = 0;
    end

    task automatic report(input string what);
        errors++;
        $display("ERROR at %0t ns: %s", $time, what);
    endtask

    function automatic void clear_stats();
        n_seen   = 0;
        sum_acc  = 0;
        hi_val   = '0;
        hi_pos   = '0;
        lo_val   = '0;
        lo_pos   = '0;
        prev_smp = '0;
        run_len  = 0;
        best_run = 0;
        mode_val = '0;
        dev_peak = 0;
    endfunction

    // Fold one sample into the set and return the statistics word it should produce
    function automatic rss_pkg::result_t next_stats(input rss_pkg::sample_t smp,
                                                    input logic lst);
        rss_pkg::result_t r;
        longint  s;
        longint  mean;
        longint  diff;
        longint  avg;
        int      pos;
        s   = longint'(smp);
        pos = n_seen;
        if (pos == 0)
        begin
            sum_acc  = s;
            hi_val   = smp;
            hi_pos   = '0;
            lo_val   = smp;
            lo_pos   = '0;
            run_len  = 1;
            best_run = 1;
            mode_val = smp;
            dev_peak = 0;
        end
        else
        begin
            // minimum only tested when the sample is not a new maximum
            if (smp > hi_val)
            begin
                hi_val = smp;
                hi_pos = rss_pkg::idx_t'(pos);
            end
            else if (smp < lo_val)
            begin
                lo_val = smp;
                lo_pos = rss_pkg::idx_t'(pos);
            end
            sum_acc += s;

            // deviation from the mean truncated towards zero, sample included
            mean = sum_acc / longint'(pos + 1);
            diff = s - mean;
            if (diff < 0)
                diff = -diff;
            if (diff > dev_peak)
                dev_peak = diff;

            // longest equal run, a tie goes to the larger value
            if (smp == prev_smp)
                run_len++;
            else
                run_len = 1;
            if (run_len > best_run || (run_len == best_run && smp > mode_val))
            begin
                best_run = run_len;
                mode_val = smp;
            end
        end
        prev_smp = smp;
        n_seen   = pos + 1;
        avg      = (sum_acc * 256) / longint'(n_seen);

        r.count         = rss_pkg::cnt_t'(n_seen);
        r.max_value     = hi_val;
        r.max_index     = hi_pos;
        r.min_value     = lo_val;
        r.min_index     = lo_pos;
        r.mode_value    = mode_val;
        r.average_q8    = rss_pkg::avg_t'(avg);
        r.max_deviation = rss_pkg::dev_t'(dev_peak);
        r.set_done      = lst || (n_seen >= rss_pkg::MAX_ITEMS);
        if (r.set_done)
            clear_stats();
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report($sformatf("word %0d field %s: got %0h, expected %0h",
                             words_checked, name, got, want));
    endtask

    task automatic compare_stats(input rss_pkg::result_t got, input rss_pkg::result_t want);
        check_field("count", 64'(got.count), 64'(want.count));
        check_field("max_value", 64'(got.max_value), 64'(want.max_value));
        check_field("max_index", 64'(got.max_index), 64'(want.max_index));
        check_field("min_value", 64'(got.min_value), 64'(want.min_value));
        check_field("min_index", 64'(got.min_index), 64'(want.min_index));
        check_field("mode_value", 64'(got.mode_value), 64'(want.mode_value));
        check_field("average_q8", 64'(got.average_q8), 64'(want.average_q8));
        check_field("max_deviation", 64'(got.max_deviation), 64'(want.max_deviation));
        check_field("set_done", 64'(got.set_done), 64'(want.set_done));
    endtask

    // Handshakes are sampled at the edge, before anything driven there settles
    always @(posedge clk)
    begin
        rss_pkg::result_t seen;
        rss_pkg::result_t want;
        if (!rst_n)
        begin
            clear_stats();
            stats_due.delete();
        end
        else
        begin
            if (samples.valid && samples.ready)
                stats_due.push_back(next_stats(samples.sample, samples.last));
            if (results.valid && results.ready)
            begin
                seen = {results.count, results.max_value, results.max_index,
                        results.min_value, results.min_index, results.mode_value,
                        results.average_q8, results.max_deviation, results.set_done};
                if (stats_due.size() == 0)
                    report("result word with no sample waiting for it");
                else
                begin
                    want = stats_due.pop_front();
                    compare_stats(seen, want);
                end
                words_checked++;
            end
        end
        pending <= stats_due.size();
    end

endmodule

// ===== tb/sv/tb_running_sample_statistics.sv =====
// Top of the running_sample_statistics testbench: clock, reset, sample stimulus and
// result back-pressure, plus the verdict. Depends on rss_pkg, the channel interfaces,
// the block itself and rss_stats_checker.
module tb_running_sample_statistics;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {FLV_WIDE, FLV_NARROW, FLV_EDGE, FLV_MID} flavour_t;

    localparam rss_pkg::sample_t SMP_MAX = 32'sh7fff_ffff;
    localparam rss_pkg::sample_t SMP_MIN = 32'sh8000_0000;
    localparam int               RANDOM_WORDS = 1100;

    logic clk = 1'b0;
    logic rst_n;
    bit   idle_on;
    int   errors;
    int   pending;

    rss_in_if  samples ();
    rss_out_if results ();

    running_sample_statistics uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .results (results)
    );

    rss_stats_checker stats_chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .results (results),
        .errors  (errors),
        .pending (pending)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Generous limit on the whole run
    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic rss_pkg::sample_t pick_sample(input flavour_t flavour);
        rss_pkg::sample_t v;
        case (flavour)
            FLV_WIDE:   v = rss_pkg::sample_t'($urandom);
            FLV_NARROW: v = rss_pkg::sample_t'(int'($urandom_range(0, 6)) - 3);
            FLV_EDGE:
                case ($urandom_range(0, 5))
                    0:       v = SMP_MAX;
                    1:       v = SMP_MIN;
                    2:       v = SMP_MAX - 1;
                    3:       v = SMP_MIN + 1;
                    4:       v = '0;
                    default: v = '1;
                endcase
            default:    v = rss_pkg::sample_t'(int'($urandom_range(0, 2000)) - 1000);
        endcase
        return v;
    endfunction

    // Offer one sample word, after a random gap, and hold it until taken
    task automatic send_sample(input rss_pkg::sample_t smp, input logic lst);
        int gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0)
        begin
            samples.valid  <= 1'b0;
            samples.sample <= rss_pkg::sample_t'($urandom);
            samples.last   <= 1'($urandom);
            repeat (gap) @(posedge clk);
        end
        samples.valid  <= 1'b1;
        samples.sample <= smp;
        samples.last   <= lst;
        do @(posedge clk); while (!samples.ready);
    endtask

    // Result side: random stalls, sometimes while a word is already waiting
    initial
    begin
        int stall;
        results.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 6) : 0;
            if (stall == 0)
                results.ready <= 1'b1;
            else
            begin
                results.ready <= 1'b0;
                if ($urandom_range(0, 1))
                    do @(posedge clk); while (!results.valid);
                repeat (stall) @(posedge clk);
                results.ready <= 1'b1;
            end
            do @(posedge clk); while (!results.valid);
        end
    end

    // Stimulus and verdict
    initial
    begin
        int       sent;
        int       len;
        flavour_t flavour;
        rst_n          = 1'b0;
        idle_on        = 1'b1;
        samples.valid  = 1'b0;
        samples.sample = '0;
        samples.last   = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // single-word sets at both extremes
        send_sample(SMP_MAX, 1'b1);
        send_sample(SMP_MIN, 1'b1);
        // extremes repeated: equal max and min keep their first index, wide deviation
        send_sample('0, 1'b0);
        send_sample(SMP_MIN, 1'b0);
        send_sample(SMP_MAX, 1'b0);
        send_sample(SMP_MAX, 1'b0);
        send_sample(SMP_MIN, 1'b0);
        send_sample(-5, 1'b1);
        // equal runs tied in length: the later, larger value wins
        send_sample(3, 1'b0);
        send_sample(3, 1'b0);
        send_sample(7, 1'b0);
        send_sample(7, 1'b0);
        send_sample(1, 1'b1);
        // tied runs where the later value is smaller: mode stays
        send_sample(7, 1'b0);
        send_sample(7, 1'b0);
        send_sample(3, 1'b0);
        send_sample(3, 1'b0);
        send_sample(-1, 1'b1);
        // negative sum: average and mean truncate towards zero
        send_sample(-1, 1'b0);
        send_sample(-2, 1'b1);

        // random sets, mostly short, with idling on most of them
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            len     = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 300)
                                                  : $urandom_range(1, 40);
            flavour = flavour_t'($urandom_range(0, 3));
            idle_on = ($urandom_range(0, 7) != 0);
            for (int k = 0; k < len; k++)
                send_sample(pick_sample(flavour), k == len - 1);
            sent += len;
        end
        samples.valid <= 1'b0;

        // drain, then allow for a stray word
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
